// File: rtl/uart_image_loader_defines.svh
// Assertion macros shared by the serial image loader RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef UART_IMAGE_LOADER_DEFINES_SVH
`define UART_IMAGE_LOADER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UIL_ASSERT_IMPL(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("uil implication check failed");

// Next-cycle implication, disabled during reset.
`define UIL_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("uil next-cycle check failed");

`endif

// File: rtl/uil_pkg.sv
// Shared types and constants of the serial image loader.
// No dependencies.
`default_nettype none

package uil_pkg;

   localparam int unsigned ADDR_WIDTH = 32;
   localparam logic [31:0] ADDR_MASK  = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

   localparam logic [7:0] SYNC_CHAR = 8'h4C;  // 'L'
   localparam logic [7:0] ACK_CHAR  = 8'h4B;  // 'K'
   localparam logic [7:0] ERR_CHAR  = 8'h45;  // 'E'

   localparam logic [31:0] IMAGE_BASE_RESET = 32'h0000_0800;
   localparam logic [31:0] MAX_LENGTH_RESET = 32'd14336;
   localparam logic [31:0] POLL_LIMIT_RESET = 32'd60000000;

   localparam logic [1:0] CSR_IMAGE_BASE = 2'd0;
   localparam logic [1:0] CSR_MAX_LENGTH = 2'd1;
   localparam logic [1:0] CSR_POLL_LIMIT = 2'd2;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        store_valid;
      logic [31:0] store_address;
      logic [7:0]  store_data;
      logic        jump_valid;
      logic        boot_kind;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/uart_image_loader.sv
// Serial boot loader engine: sync with timeout, length, image store and checksum check.
// Depends on uil_pkg and uart_image_loader_defines.svh.
//
// Usage:
//   req channel: one beat per poll; mode 0 is a tick, mode 1 carries rx_byte.
//   rsp channel: at most one beat per poll, holding the reply byte, the image
//   byte write and the jump request. Polls that cause nothing give no beat.
//   csr channel: always ready; index 0 image_base, 1 max_length,
//   2 poll_limit; other indexes are dropped. Write only while idle.
// Timing:
//   A poll is held in the input register on acceptance and processed there;
//   its result beat is registered on rsp and can be taken at an edge with
//   rsp_stall low. One poll per cycle is sustained while the skid is empty.
// Stall:
//   A result register plus a one-entry skid buffer decouple the sides; a
//   poll keeps flowing while one result waits. req_stall rises only when the
//   skid is full and a poll is waiting in the input register.
// Reset:
//   Returns to waiting for sync with the timeout counter at zero and the
//   registers at their defaults; pending beats are dropped.
`default_nettype none
`include "uart_image_loader_defines.svh"

module uart_image_loader (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire uil_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output uil_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_data
);
   import uil_pkg::*;

   localparam logic [2:0] PH_WAIT = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_DATA = 3'd2;
   localparam logic [2:0] PH_SUM  = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   logic [31:0] image_base_ff, max_length_ff, poll_limit_ff;

   logic        in_valid_ff;
   req_type     in_ff;
   logic        out_valid_ff, skid_valid_ff;
   rsp_type     out_ff, skid_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] poll_ff, poll_in;
   logic [1:0]  lbs_ff, lbs_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] idx_ff, idx_in;
   logic [7:0]  sum_ff, sum_in;

   logic        emit;
   rsp_type     res;
   logic        proc, req_take, rsp_take;
   logic [31:0] len_acc, idx_next, poll_next;

   assign csr_ready = 1'b1;
   assign proc      = in_valid_ff && !skid_valid_ff;
   assign req_stall = in_valid_ff && skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   assign len_acc   = len_ff | ({24'd0, in_ff.rx_byte} << {lbs_ff, 3'b000});
   assign idx_next  = idx_ff + 32'd1;
   assign poll_next = (poll_ff == 32'hFFFF_FFFF) ? poll_ff : poll_ff + 32'd1;

   always_comb begin
      phase_in = phase_ff;
      poll_in  = poll_ff;
      lbs_in   = lbs_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      emit     = 1'b0;
      res      = '0;
      unique case (phase_ff)
         PH_WAIT: begin
            if (in_ff.mode && in_ff.rx_byte == SYNC_CHAR && poll_ff < poll_limit_ff) begin
               emit        = 1'b1;
               res.tx_valid = 1'b1;
               res.tx_byte  = ACK_CHAR;
               phase_in    = PH_LEN;
               lbs_in      = 2'd0;
               len_in      = 32'd0;
            end else begin
               poll_in = poll_next;
               if (poll_next >= poll_limit_ff) begin
                  emit           = 1'b1;
                  res.jump_valid = 1'b1;
                  res.boot_kind  = 1'b1;
                  phase_in       = PH_DONE;
               end
            end
         end
         PH_LEN: begin
            if (in_ff.mode) begin
               len_in = len_acc;
               if (lbs_ff != 2'd3) begin
                  lbs_in = lbs_ff + 2'd1;
               end else begin
                  lbs_in = 2'd0;
                  if (len_acc > max_length_ff) begin
                     emit         = 1'b1;
                     res.tx_valid = 1'b1;
                     res.tx_byte  = ERR_CHAR;
                     phase_in     = PH_WAIT;
                     poll_in      = 32'd0;
                  end else begin
                     idx_in   = 32'd0;
                     sum_in   = 8'd0;
                     phase_in = (len_acc == 32'd0) ? PH_SUM : PH_DATA;
                  end
               end
            end
         end
         PH_DATA: begin
            if (in_ff.mode) begin
               emit              = 1'b1;
               res.store_valid   = 1'b1;
               res.store_address = (image_base_ff + idx_ff) & ADDR_MASK;
               res.store_data    = in_ff.rx_byte;
               sum_in            = sum_ff + in_ff.rx_byte;
               idx_in            = idx_next;
               if (idx_next >= len_ff) phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            if (in_ff.mode) begin
               emit         = 1'b1;
               res.tx_valid = 1'b1;
               if (in_ff.rx_byte == sum_ff) begin
                  res.tx_byte    = ACK_CHAR;
                  res.jump_valid = 1'b1;
                  phase_in       = PH_DONE;
               end else begin
                  res.tx_byte = ERR_CHAR;
                  phase_in    = PH_WAIT;
                  poll_in     = 32'd0;
               end
            end
         end
         default: begin
            // done: everything is ignored until reset
         end
      endcase
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_base_ff <= IMAGE_BASE_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
         poll_limit_ff <= POLL_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_BASE: image_base_ff <= csr_data;
            CSR_MAX_LENGTH: max_length_ff <= csr_data;
            CSR_POLL_LIMIT: poll_limit_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // loader state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         poll_ff  <= 32'd0;
         lbs_ff   <= 2'd0;
         len_ff   <= 32'd0;
         idx_ff   <= 32'd0;
         sum_ff   <= 8'd0;
      end else if (proc) begin
         phase_ff <= phase_in;
         poll_ff  <= poll_in;
         lbs_ff   <= lbs_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (proc) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_ff <= req_data;
   end

   // result register and skid; a new result lands in the skid only while
   // the result register is held by the receiver
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_take) skid_valid_ff <= 1'b0;
         end else if (proc && emit) begin
            if (out_valid_ff && rsp_stall) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) out_ff <= skid_ff;
      end else if (proc && emit) begin
         if (out_valid_ff && rsp_stall) begin
            skid_ff <= res;
         end else begin
            out_ff <= res;
         end
      end
   end

   `UIL_ASSERT_IMPL(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `UIL_ASSERT_NEXT(a_done_sticks, phase_ff == PH_DONE, phase_ff == PH_DONE)
   `UIL_ASSERT_IMPL(a_len_count_in_len, lbs_ff != 2'd0, phase_ff == PH_LEN)
   `UIL_ASSERT_NEXT(a_jump_enters_done, proc && emit && res.jump_valid, phase_ff == PH_DONE)

endmodule

`default_nettype wire

// File: test/tb_uart_image_loader.sv
// Self-checking testbench for the serial image loader (uart_image_loader).
// Depends on uil_pkg and the loader RTL; drives polls, CSR writes and random back-pressure,
// and checks every result beat against an in-bench model of the load sequence.
module tb_uart_image_loader;
   import uil_pkg::*;

   localparam logic [1:0] CSR_UNUSED        = 2'd3;
   localparam int         SETTLE_CYCLES     = 6;
   localparam int         HOLD_CYCLES       = 150;
   localparam int         WATCHDOG_LIMIT    = 3000;
   localparam int         ITEMS_PER_SETTING = 360;

   typedef enum logic [2:0] {
      LD_SYNC, LD_LENGTH, LD_IMAGE, LD_CHECK, LD_BOOTED
   } load_phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // loader model state and register copies
   logic [31:0] cfg_base    = IMAGE_BASE_RESET;
   logic [31:0] cfg_max_len = MAX_LENGTH_RESET;
   logic [31:0] cfg_timeout = POLL_LIMIT_RESET;
   load_phase_type m_phase  = LD_SYNC;
   logic [31:0] m_polls     = '0;
   logic [1:0]  m_len_seen  = '0;
   logic [31:0] m_length    = '0;
   logic [31:0] m_index     = '0;
   logic [7:0]  m_sum       = '0;

   rsp_type outcomes_due[$];
   int      n_errors   = 0;
   int      polls_used = 0;
   int      idle_count = 0;
   bit      steady_sender = 1'b0;
   bit      hold_req = 1'b0;
   int      hold_left = 0;
   int      stall_left = 0;
   int      rx_calm = 0;
   int      tx_calm = 0;

   uart_image_loader u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // mostly no gap, some short ones, a few long; now and then a run with none at all
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // advances the loader state by one poll; returns 1 when the poll yields a beat
   function automatic logic step_loader(input req_type item, output rsp_type out);
      logic emit;
      emit = 1'b0;
      out  = '0;
      if (m_phase != LD_BOOTED && (item.mode || m_phase == LD_SYNC)) polls_used++;
      case (m_phase)
         LD_SYNC: begin
            if (item.mode && item.rx_byte == SYNC_CHAR && m_polls < cfg_timeout) begin
               out.tx_valid = 1'b1;
               out.tx_byte  = ACK_CHAR;
               emit         = 1'b1;
               m_phase      = LD_LENGTH;
               m_len_seen   = '0;
               m_length     = '0;
            end else begin
               if (m_polls != '1) m_polls++;
               if (m_polls >= cfg_timeout) begin
                  out.jump_valid = 1'b1;
                  out.boot_kind  = 1'b1;
                  emit           = 1'b1;
                  m_phase        = LD_BOOTED;
               end
            end
         end
         LD_LENGTH: if (item.mode) begin
            m_length |= 32'(item.rx_byte) << (8 * m_len_seen);
            if (m_len_seen != 2'd3) m_len_seen++;
            else begin
               m_len_seen = '0;
               if (m_length > cfg_max_len) begin
                  out.tx_valid = 1'b1;
                  out.tx_byte  = ERR_CHAR;
                  emit         = 1'b1;
                  m_phase      = LD_SYNC;
                  m_polls      = '0;
               end else begin
                  m_index = '0;
                  m_sum   = '0;
                  m_phase = (m_length == 0) ? LD_CHECK : LD_IMAGE;
               end
            end
         end
         LD_IMAGE: if (item.mode) begin
            out.store_valid   = 1'b1;
            out.store_address = (cfg_base + m_index) & ADDR_MASK;
            out.store_data    = item.rx_byte;
            emit              = 1'b1;
            m_sum             = m_sum + item.rx_byte;
            m_index++;
            if (m_index >= m_length) m_phase = LD_CHECK;
         end
         LD_CHECK: if (item.mode) begin
            emit         = 1'b1;
            out.tx_valid = 1'b1;
            if (item.rx_byte == m_sum) begin
               out.tx_byte    = ACK_CHAR;
               out.jump_valid = 1'b1;
               m_phase        = LD_BOOTED;
            end else begin
               out.tx_byte = ERR_CHAR;
               m_phase     = LD_SYNC;
               m_polls     = '0;
            end
         end
         default: ;
      endcase
      return emit;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         n_errors++;
      end
   endfunction

   // result side: checks each accepted beat against the oldest outcome due
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            $error("result beat with nothing due: %h", rsp_data);
            n_errors++;
         end else begin
            want = outcomes_due.pop_front();
            check_field("tx_valid", want.tx_valid, rsp_data.tx_valid);
            check_field("tx_byte", want.tx_byte, rsp_data.tx_byte);
            check_field("store_valid", want.store_valid, rsp_data.store_valid);
            check_field("store_address", want.store_address, rsp_data.store_address);
            check_field("store_data", want.store_data, rsp_data.store_data);
            check_field("jump_valid", want.jump_valid, rsp_data.jump_valid);
            check_field("boot_kind", want.boot_kind, rsp_data.boot_kind);
         end
      end
   end

   // receiver stalls: random gaps, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap(rx_calm);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_poll(input logic mode, input logic [7:0] value);
      int      gap;
      req_type item;
      rsp_type out;
      gap = steady_sender ? 0 : pick_gap(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.mode    = mode;
      item.rx_byte = value;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (step_loader(item, out)) outcomes_due.push_back(out);
   endtask

   // drop valid, let every due beat arrive, then give in-flight polls time to retire
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_IMAGE_BASE: cfg_base    = value;
         CSR_MAX_LENGTH: cfg_max_len = value;
         CSR_POLL_LIMIT: cfg_timeout = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic stray_tick();
      if ($urandom_range(0, 7) == 0) send_poll(1'b0, 8'($urandom));
   endtask

   // waiting-phase traffic that never starts a load
   task automatic sync_noise();
      logic [7:0] value;
      value = 8'($urandom);
      if ($urandom_range(0, 1)) send_poll(1'b0, value);
      else begin
         if (value == SYNC_CHAR) value = ~value;
         send_poll(1'b1, value);
      end
   endtask

   // one sync/length/image sequence that always ends in an error reply
   task automatic random_load();
      int          n_noise;
      int          upper;
      int          pick;
      logic [31:0] length;
      logic [7:0]  sum;
      logic [7:0]  value;
      n_noise = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 8) : $urandom_range(0, 2);
      repeat (n_noise) sync_noise();
      send_poll(1'b1, SYNC_CHAR);
      pick  = $urandom_range(0, 9);
      upper = (cfg_max_len < 32) ? int'(cfg_max_len) : 32;
      if (pick == 0 && cfg_max_len != '1) begin
         length = $urandom;
         if (length <= cfg_max_len) length = cfg_max_len + 32'd1;
      end else if (pick == 1) length = '0;
      else if (pick == 2) length = upper;
      else length = $urandom_range(0, upper);
      for (int k = 0; k < 4; k++) begin
         stray_tick();
         send_poll(1'b1, length[8*k +: 8]);
      end
      if (length > cfg_max_len) return;
      sum = '0;
      for (int unsigned i = 0; i < length; i++) begin
         value = 8'($urandom);
         stray_tick();
         send_poll(1'b1, value);
         sum = sum + value;
      end
      stray_tick();
      send_poll(1'b1, sum ^ 8'($urandom_range(1, 255)));
   endtask

   task automatic test_directed_defaults();
      send_poll(1'b0, 8'hA5);
      send_poll(1'b1, 8'h00);
      send_poll(1'b1, 8'hFF);
      send_poll(1'b1, SYNC_CHAR);
      send_poll(1'b0, 8'h00);          // tick mid-length is dropped
      send_poll(1'b1, 8'h03);
      send_poll(1'b1, 8'h00);
      send_poll(1'b1, 8'h00);
      send_poll(1'b1, 8'h00);
      send_poll(1'b1, 8'hFF);
      send_poll(1'b0, 8'hFF);
      send_poll(1'b1, 8'h00);
      send_poll(1'b1, 8'h80);
      send_poll(1'b1, 8'h80);          // sum is 0x7F: bad checksum
      send_poll(1'b1, SYNC_CHAR);      // zero length, nonzero checksum
      repeat (4) send_poll(1'b1, 8'h00);
      send_poll(1'b1, 8'h01);
      send_poll(1'b1, SYNC_CHAR);      // largest length, over the limit
      repeat (4) send_poll(1'b1, 8'hFF);
   endtask

   task automatic test_address_wrap();
      wait_idle();
      write_csr(CSR_IMAGE_BASE, 32'hFFFF_FFFE);
      send_poll(1'b1, SYNC_CHAR);
      send_poll(1'b1, 8'h04);
      repeat (3) send_poll(1'b1, 8'h00);
      send_poll(1'b1, 8'h11);
      send_poll(1'b1, 8'h22);
      send_poll(1'b1, 8'h33);
      send_poll(1'b1, 8'h44);
      send_poll(1'b1, 8'h00);
   endtask

   task automatic test_random_loads(input logic [31:0] base, input logic [31:0] max_len,
                                    input logic [31:0] timeout);
      int stop_at;
      wait_idle();
      write_csr(CSR_IMAGE_BASE, base);
      write_csr(CSR_MAX_LENGTH, max_len);
      write_csr(CSR_POLL_LIMIT, timeout);
      stop_at = polls_used + ITEMS_PER_SETTING;
      while (polls_used < stop_at) random_load();
   endtask

   task automatic test_unused_register();
      wait_idle();
      write_csr(CSR_UNUSED, $urandom);
      random_load();
   endtask

   // receiver holds off while the sender streams a long image with no gaps
   task automatic test_back_pressure();
      logic [7:0] sum;
      logic [7:0] value;
      wait_idle();
      steady_sender = 1'b1;
      hold_req      = 1'b1;
      sum           = '0;
      send_poll(1'b1, SYNC_CHAR);
      send_poll(1'b1, 8'd40);
      repeat (3) send_poll(1'b1, 8'h00);
      repeat (40) begin
         value = 8'($urandom);
         send_poll(1'b1, value);
         sum = sum + value;
      end
      send_poll(1'b1, ~sum);
      steady_sender = 1'b0;
      wait_idle();
   endtask

   // ends the load life: either a sync timeout or a clean image with a good checksum
   task automatic test_boot();
      logic [31:0] timeout;
      logic [31:0] length;
      logic [7:0]  sum;
      logic [7:0]  value;
      wait_idle();
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 2))
            0:       timeout = '0;
            1:       timeout = 32'd1;
            default: timeout = $urandom_range(2, 30);
         endcase
         write_csr(CSR_POLL_LIMIT, timeout);
         if (timeout == 0 && $urandom_range(0, 1)) send_poll(1'b1, SYNC_CHAR);
         while (m_phase != LD_BOOTED) sync_noise();
      end else begin
         length = $urandom_range(0, (cfg_max_len < 12) ? cfg_max_len : 12);
         sum    = '0;
         send_poll(1'b1, SYNC_CHAR);
         for (int k = 0; k < 4; k++) send_poll(1'b1, length[8*k +: 8]);
         for (int unsigned i = 0; i < length; i++) begin
            value = 8'($urandom);
            stray_tick();
            send_poll(1'b1, value);
            sum = sum + value;
         end
         send_poll(1'b1, sum);
      end
   endtask

   task automatic test_ignored_after_jump();
      repeat (12) begin
         case ($urandom_range(0, 2))
            0:       send_poll(1'b1, SYNC_CHAR);
            1:       send_poll(1'b0, 8'($urandom));
            default: send_poll(1'b1, 8'($urandom));
         endcase
      end
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_defaults();
      test_address_wrap();
      test_random_loads(32'hFFFF_FFF0, 32'd24, 32'hFFFF_FFFF);
      test_unused_register();
      test_random_loads(32'h0000_0000, 32'h0000_0000, 32'd1000);
      test_random_loads($urandom, 32'hFFFF_FFFF, $urandom_range(200, 100000));
      test_back_pressure();
      test_random_loads($urandom, $urandom_range(8, 60), POLL_LIMIT_RESET);
      test_boot();
      test_ignored_after_jump();
      if (n_errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/uil_pkg.sv
rtl/uart_image_loader.sv
test/tb_uart_image_loader.sv
